// ===== design/lspq_pkg.sv =====
// ----------------------------------------------------------------------------
// lspq_pkg: shared types and codes for the linear scan priority queue
// Item layouts, status and function codes, and the micro-instruction format.
// ----------------------------------------------------------------------------
package lspq_pkg;

  localparam int PC_W = 5;

  localparam logic [1:0] FN_ENQ      = 2'd0;
  localparam logic [1:0] FN_DEQ      = 2'd1;
  localparam logic [1:0] FN_PEEK_OLD = 2'd2;
  localparam logic [1:0] FN_PEEK_NEW = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic signed [31:0]  in_data;
    logic signed [15:0]  in_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  out_data;
    logic signed [15:0]  out_priority;
  } out_item_t;

  // Jump conditions of the sequencer.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NOSTART   = 4'd2,
    C_ENQ       = 4'd3,
    C_EMPTY     = 4'd4,
    C_FULL      = 4'd5,
    C_OLD       = 4'd6,
    C_NEW       = 4'd7,
    C_IDX_END   = 4'd8,
    C_IDX_MORE  = 4'd9,
    C_IDX_LAST  = 4'd10,
    C_BEST_LAST = 4'd11
  } cond_t;

  typedef enum logic [1:0] {
    RA_IDX  = 2'd0,
    RA_ZERO = 2'd1,
    RA_LAST = 2'd2
  } rd_sel_t;

  typedef enum logic {
    WA_TAIL  = 1'b0,
    WA_SHIFT = 1'b1
  } wr_sel_t;

  typedef enum logic [1:0] {
    OS_ZERO = 2'd0,
    OS_RDQ  = 2'd1,
    OS_BEST = 2'd2
  } out_sel_t;

  typedef struct packed {
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             rd_en;
    rd_sel_t          rd_sel;
    logic             wr_en;
    wr_sel_t          wr_sel;
    logic             idx_clr;
    logic             idx_inc;
    logic             idx_best;
    logic             best_load;
    logic             best_cmp;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             emit;
    logic [1:0]       status;
    out_sel_t         out_sel;
  } uword_t;

  // Datapath status seen by the sequencer's jump logic.
  typedef struct packed {
    logic enq;
    logic empty;
    logic full;
    logic old;
    logic newest;
    logic idx_end;
    logic idx_more;
    logic best_last;
  } flags_t;

endpackage

// ===== design/lspq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lspq_ctrl: micro-program sequencer
// Step counter, control store and conditional jump logic.
// ----------------------------------------------------------------------------
module lspq_ctrl
  import lspq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  output logic   busy,
  output logic   accept,
  output uword_t uw
);

  localparam logic [PC_W-1:0] P_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] P_DISP     = 5'd1;
  localparam logic [PC_W-1:0] P_CHK_EMP  = 5'd2;
  localparam logic [PC_W-1:0] P_CHK_OLD  = 5'd3;
  localparam logic [PC_W-1:0] P_CHK_NEW  = 5'd4;
  localparam logic [PC_W-1:0] P_DEQ_RD0  = 5'd5;
  localparam logic [PC_W-1:0] P_DEQ_LD0  = 5'd6;
  localparam logic [PC_W-1:0] P_SCAN     = 5'd7;
  localparam logic [PC_W-1:0] P_SCAN_END = 5'd8;
  localparam logic [PC_W-1:0] P_SH_SET   = 5'd9;
  localparam logic [PC_W-1:0] P_SH_RD    = 5'd10;
  localparam logic [PC_W-1:0] P_SH_LOOP  = 5'd11;
  localparam logic [PC_W-1:0] P_SH_LAST  = 5'd12;
  localparam logic [PC_W-1:0] P_DEQ_END  = 5'd13;
  localparam logic [PC_W-1:0] P_ENQ      = 5'd14;
  localparam logic [PC_W-1:0] P_ENQ_WR   = 5'd15;
  localparam logic [PC_W-1:0] P_OVF      = 5'd16;
  localparam logic [PC_W-1:0] P_EMPTY    = 5'd17;
  localparam logic [PC_W-1:0] P_OLD_RD   = 5'd18;
  localparam logic [PC_W-1:0] P_PEEK_OUT = 5'd19;
  localparam logic [PC_W-1:0] P_NEW_RD   = 5'd20;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            take;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      P_IDLE: begin
        w.cond = C_NOSTART; w.target = P_IDLE;
      end
      P_DISP: begin
        w.idx_clr = 1'b1; w.cond = C_ENQ; w.target = P_ENQ;
      end
      P_CHK_EMP: begin
        w.cond = C_EMPTY; w.target = P_EMPTY;
      end
      P_CHK_OLD: begin
        w.cond = C_OLD; w.target = P_OLD_RD;
      end
      P_CHK_NEW: begin
        w.cond = C_NEW; w.target = P_NEW_RD;
      end
      P_DEQ_RD0: begin
        w.rd_en = 1'b1; w.rd_sel = RA_IDX; w.idx_inc = 1'b1;
      end
      P_DEQ_LD0: begin
        w.best_load = 1'b1; w.cond = C_IDX_END; w.target = P_SH_SET;
      end
      P_SCAN: begin
        // read the next entry while comparing the one read last cycle
        w.rd_en = 1'b1; w.rd_sel = RA_IDX; w.idx_inc = 1'b1; w.best_cmp = 1'b1;
        w.cond = C_IDX_MORE; w.target = P_SCAN;
      end
      P_SCAN_END: begin
        w.best_cmp = 1'b1;
      end
      P_SH_SET: begin
        w.idx_best = 1'b1; w.cond = C_BEST_LAST; w.target = P_DEQ_END;
      end
      P_SH_RD: begin
        w.rd_en = 1'b1; w.rd_sel = RA_IDX; w.idx_inc = 1'b1;
        w.cond = C_IDX_LAST; w.target = P_SH_LAST;
      end
      P_SH_LOOP: begin
        w.wr_en = 1'b1; w.wr_sel = WA_SHIFT;
        w.rd_en = 1'b1; w.rd_sel = RA_IDX; w.idx_inc = 1'b1;
        w.cond = C_IDX_MORE; w.target = P_SH_LOOP;
      end
      P_SH_LAST: begin
        w.wr_en = 1'b1; w.wr_sel = WA_SHIFT;
      end
      P_DEQ_END: begin
        w.cnt_dec = 1'b1; w.emit = 1'b1; w.status = ST_OK; w.out_sel = OS_BEST;
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
      P_ENQ: begin
        w.cond = C_FULL; w.target = P_OVF;
      end
      P_ENQ_WR: begin
        w.wr_en = 1'b1; w.wr_sel = WA_TAIL; w.cnt_inc = 1'b1;
        w.emit = 1'b1; w.status = ST_OK; w.out_sel = OS_ZERO;
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
      P_OVF: begin
        w.emit = 1'b1; w.status = ST_OVERFLOW; w.out_sel = OS_ZERO;
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
      P_EMPTY: begin
        w.emit = 1'b1; w.status = ST_EMPTY; w.out_sel = OS_ZERO;
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
      P_OLD_RD: begin
        w.rd_en = 1'b1; w.rd_sel = RA_ZERO;
      end
      P_PEEK_OUT: begin
        w.emit = 1'b1; w.status = ST_OK; w.out_sel = OS_RDQ;
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
      P_NEW_RD: begin
        w.rd_en = 1'b1; w.rd_sel = RA_LAST;
        w.cond = C_ALWAYS; w.target = P_PEEK_OUT;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = P_IDLE;
      end
    endcase
    return w;
  endfunction

  assign uw     = ucode(pc_r);
  assign busy   = (pc_r != P_IDLE);
  assign accept = start && !busy;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOSTART:   take = !start;
      C_ENQ:       take = flags.enq;
      C_EMPTY:     take = flags.empty;
      C_FULL:      take = flags.full;
      C_OLD:       take = flags.old;
      C_NEW:       take = flags.newest;
      C_IDX_END:   take = flags.idx_end;
      C_IDX_MORE:  take = flags.idx_more;
      C_IDX_LAST:  take = !flags.idx_more;
      C_BEST_LAST: take = flags.best_last;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/lspq_dpath.sv =====
// ----------------------------------------------------------------------------
// lspq_dpath: entry memory and scan/shift datapath
// One read and one write port, index and count registers, best-entry tracker.
// ----------------------------------------------------------------------------
module lspq_dpath
  import lspq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  in_item,
  input  uword_t    uw,
  output flags_t    flags,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 1;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] data;
  } ent_t;

  ent_t            mem [DEPTH];
  ent_t            rd_q;
  logic [AW-1:0]   rd_idx_r;
  in_item_t        cmd_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r;
  logic [AW-1:0]   best_idx_r;
  ent_t            best_r;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   rd_addr, wr_addr;
  ent_t            wr_data;
  logic            better;
  logic            out_valid_r;
  out_item_t       out_r;

  assign cnt_m1 = count_r - 1'b1;

  always_comb begin
    unique case (uw.rd_sel)
      RA_IDX:  rd_addr = idx_r[AW-1:0];
      RA_ZERO: rd_addr = '0;
      RA_LAST: rd_addr = cnt_m1[AW-1:0];
      default: rd_addr = '0;
    endcase
    unique case (uw.wr_sel)
      WA_TAIL: begin
        wr_addr = count_r[AW-1:0];
        wr_data = '{prio: cmd_r.in_priority, data: cmd_r.in_data};
      end
      WA_SHIFT: begin
        // move the entry just read one place toward the oldest end
        wr_addr = rd_idx_r - 1'b1;
        wr_data = rd_q;
      end
      default: begin
        wr_addr = '0;
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (uw.rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // Strict compare keeps the oldest entry on ties.
  assign better = (rd_q.prio < best_r.prio);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    if (uw.idx_clr) begin
      idx_r <= '0;
    end else if (uw.idx_best) begin
      idx_r <= CW'(best_idx_r) + 1'b1;
    end else if (uw.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (uw.best_load || (uw.best_cmp && better)) begin
      best_r     <= rd_q;
      best_idx_r <= rd_idx_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (uw.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (uw.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= uw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_r.status <= uw.status;
      unique case (uw.out_sel)
        OS_ZERO: begin
          out_r.out_data     <= '0;
          out_r.out_priority <= '0;
        end
        OS_RDQ: begin
          out_r.out_data     <= rd_q.data;
          out_r.out_priority <= rd_q.prio;
        end
        OS_BEST: begin
          out_r.out_data     <= best_r.data;
          out_r.out_priority <= best_r.prio;
        end
        default: begin
          out_r.out_data     <= '0;
          out_r.out_priority <= '0;
        end
      endcase
    end
  end

  always_comb begin
    flags.enq       = (cmd_r.func == FN_ENQ);
    flags.empty     = (count_r == '0);
    flags.full      = (count_r == CW'(DEPTH));
    flags.old       = (cmd_r.func == FN_PEEK_OLD);
    flags.newest    = (cmd_r.func == FN_PEEK_NEW);
    flags.idx_end   = (idx_r >= count_r);
    flags.idx_more  = ((XW'(idx_r) + 1'b1) < XW'(count_r));
    flags.best_last = ((XW'(best_idx_r) + 1'b1) >= XW'(count_r));
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/linear_scan_priority_queue_unit.sv =====
// The dequeue time is set by the single memory read port: one entry a cycle
// in the minimum scan and again in the gap-closing shift.
// One item at a time; the next item is accepted during the result strobe.
// Synchronous active-low reset empties the queue and returns to idle.
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_unit: arrival-ordered min-priority queue
// Microcoded sequencer driving an entry memory with scan and shift loops.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue_unit
  import lspq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  flags_t flags;
  uword_t uw;
  logic   accept;

  lspq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .flags  (flags),
    .busy   (busy),
    .accept (accept),
    .uw     (uw)
  );

  lspq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .uw        (uw),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== design/lspq_checker.sv =====
// ----------------------------------------------------------------------------
// lspq_checker: port-level checks for the priority queue unit
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module lspq_checker
  import lspq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.out_data == '0 && out_item.out_priority == '0))
    else $error("error result carries nonzero payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_OVERFLOW ||
                   out_item.status == ST_EMPTY))
    else $error("undefined status code");

endmodule

bind linear_scan_priority_queue_unit lspq_checker u_lspq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
